/* rtl/alpe_pkg.sv */
// alpe_pkg: shared types, register codes and pulse helper for the led pulse encoder
// no dependencies; imported by every module under rtl

package alpe_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] RST_BIT_PERIOD = COUNT_WIDTH'(30);
    localparam logic [COUNT_WIDTH-1:0] RST_ZERO_HIGH  = COUNT_WIDTH'(8);
    localparam logic [COUNT_WIDTH-1:0] RST_ONE_HIGH   = COUNT_WIDTH'(17);

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] bit_period_cycles;
        logic [COUNT_WIDTH-1:0] zero_high_cycles;
        logic [COUNT_WIDTH-1:0] one_high_cycles;
    } t_cfg;

    // line is high while the cycle count is below the pulse length clipped to the period
    function automatic logic pulse_level(input logic msb,
                                         input logic [COUNT_WIDTH-1:0] cycle,
                                         input t_cfg cfg);
        logic [COUNT_WIDTH-1:0] high;
        high = msb ? cfg.one_high_cycles : cfg.zero_high_cycles;
        return (cycle < high) && (cycle < cfg.bit_period_cycles);
    endfunction

endpackage

/* rtl/alpe_in_if.sv */
// alpe_in_if: input channel carrying commands and pixel bytes
// depends on nothing

interface alpe_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel_byte;
    logic       last_byte;

    modport source (output valid, cmd, pixel_byte, last_byte, input ready);
    modport sink   (input valid, cmd, pixel_byte, last_byte, output ready);
endinterface

/* rtl/alpe_out_if.sv */
// alpe_out_if: result channel carrying line level and status flags
// depends on nothing

interface alpe_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic holding_empty;
    logic busy_res;
    logic write_accepted;
    logic frame_done;

    modport source (output valid, line_level, holding_empty, busy_res, write_accepted,
                    frame_done, input ready);
    modport sink   (input valid, line_level, holding_empty, busy_res, write_accepted,
                    frame_done, output ready);
endinterface

/* rtl/addressable_led_pulse_encoder_unit.sv */
// addressable_led_pulse_encoder_unit: top level of the single-wire led strip transmitter
// depends on alpe_pkg, alpe_in_if, alpe_out_if, alpe_cfg, alpe_core
//
// usage:
//   input channel i_in carries one command per transfer: a tick (one line clock)
//   or a pixel byte write into the one-byte holding register, with a frame-end mark
//   output channel o_out returns exactly one result per input transfer: line level,
//   holding register empty, busy, write accepted and frame done
//   apb port sets bit period and the high times of zero and one bits; reads return them
// timing:
//   an input transfer is captured in the input register, processed by the state logic
//   once the result register is free or being taken, and lands in the result register
//   one transfer per cycle sustained while o_out.ready stays high; the single state
//   update per item is the loop that sets this figure
// reset:
//   synchronous active-low; clears holding and shift state, counters and both channel
//   stages; registers return to period 30, zero high 8, one high 17
// stall:
//   when o_out.ready is low the result register holds, the input register fills and
//   i_in.ready drops; no state advances until the result transfer completes

module addressable_led_pulse_encoder_unit
    import alpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    alpe_in_if.sink               i_in,
    alpe_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;

    alpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    alpe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* rtl/alpe_cfg.sv */
// alpe_cfg: apb register block for bit period and pulse lengths
// depends on alpe_pkg

module alpe_cfg
    import alpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BIT_PERIOD: n_cfg.bit_period_cycles = pwdata[COUNT_WIDTH-1:0];
                REG_ZERO_HIGH:  n_cfg.zero_high_cycles  = pwdata[COUNT_WIDTH-1:0];
                REG_ONE_HIGH:   n_cfg.one_high_cycles   = pwdata[COUNT_WIDTH-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIT_PERIOD: prdata = DATA_WIDTH'(r_cfg.bit_period_cycles);
            REG_ZERO_HIGH:  prdata = DATA_WIDTH'(r_cfg.zero_high_cycles);
            REG_ONE_HIGH:   prdata = DATA_WIDTH'(r_cfg.one_high_cycles);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period_cycles <= RST_BIT_PERIOD;
            r_cfg.zero_high_cycles  <= RST_ZERO_HIGH;
            r_cfg.one_high_cycles   <= RST_ONE_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* rtl/alpe_core.sv */
// alpe_core: input register, holding and shift state, bit timing and result register
// depends on alpe_pkg, alpe_in_if, alpe_out_if

module alpe_core
    import alpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    alpe_in_if.sink     i_in,
    alpe_out_if.source  o_out
);

    logic                   r_in_vld;
    logic                   r_in_cmd;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;

    logic [7:0]             r_hold_byte, n_hold_byte;
    logic                   r_hold_full, n_hold_full;
    logic                   r_hold_last, n_hold_last;
    logic [7:0]             r_shift_byte, n_shift_byte;
    logic [3:0]             r_bits_left, n_bits_left;
    logic                   r_shift_last, n_shift_last;
    logic [COUNT_WIDTH-1:0] r_cycle, n_cycle;
    logic                   r_done, n_done;

    logic                   r_out_vld;
    logic                   r_level, n_level;
    logic                   r_empty;
    logic                   r_busy;
    logic                   r_acc, n_acc;
    logic                   r_fdone;

    logic                   advance;
    logic [COUNT_WIDTH:0]   next_cycle;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_comb begin
        n_hold_byte  = r_hold_byte;
        n_hold_full  = r_hold_full;
        n_hold_last  = r_hold_last;
        n_shift_byte = r_shift_byte;
        n_bits_left  = r_bits_left;
        n_shift_last = r_shift_last;
        n_cycle      = r_cycle;
        n_done       = r_done;
        n_acc        = 1'b0;
        n_level      = 1'b0;
        next_cycle   = '0;
        if (r_in_cmd == CMD_WRITE) begin
            if (!r_hold_full) begin
                n_hold_byte = r_in_byte;
                n_hold_full = 1'b1;
                n_hold_last = r_in_last;
                n_done      = 1'b0;
                n_acc       = 1'b1;
            end
            if (r_bits_left == '0 && n_hold_full) begin
                n_level = pulse_level(n_hold_byte[7], '0, i_cfg);
            end else begin
                n_level = (r_bits_left != '0) && pulse_level(r_shift_byte[7], r_cycle, i_cfg);
            end
        end else begin
            // load a waiting byte at the start of the tick
            if (r_bits_left == '0 && r_hold_full) begin
                n_shift_byte = r_hold_byte;
                n_shift_last = r_hold_last;
                n_bits_left  = BITS_PER_BYTE;
                n_cycle      = '0;
                n_hold_full  = 1'b0;
            end
            next_cycle = {1'b0, n_cycle} + 1'b1;
            n_level = (n_bits_left != '0) && pulse_level(n_shift_byte[7], n_cycle, i_cfg);
            if (n_bits_left != '0) begin
                if (next_cycle >= {1'b0, i_cfg.bit_period_cycles}) begin
                    n_cycle      = '0;
                    n_shift_byte = {n_shift_byte[6:0], 1'b0};
                    n_bits_left  = n_bits_left - 1'b1;
                    if (n_bits_left == '0 && n_shift_last) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_cycle = next_cycle[COUNT_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_hold_byte  <= '0;
            r_hold_full  <= 1'b0;
            r_hold_last  <= 1'b0;
            r_shift_byte <= '0;
            r_bits_left  <= '0;
            r_shift_last <= 1'b0;
            r_cycle      <= '0;
            r_done       <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_hold_byte  <= n_hold_byte;
                r_hold_full  <= n_hold_full;
                r_hold_last  <= n_hold_last;
                r_shift_byte <= n_shift_byte;
                r_bits_left  <= n_bits_left;
                r_shift_last <= n_shift_last;
                r_cycle      <= n_cycle;
                r_done       <= n_done;
                r_out_vld    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.cmd;
            r_in_byte <= i_in.pixel_byte;
            r_in_last <= i_in.last_byte;
        end
        if (advance) begin
            r_level <= n_level;
            r_empty <= !n_hold_full;
            r_busy  <= n_hold_full || (n_bits_left != '0);
            r_acc   <= n_acc;
            r_fdone <= n_done;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.line_level     = r_level;
    assign o_out.holding_empty  = r_empty;
    assign o_out.busy_res       = r_busy;
    assign o_out.write_accepted = r_acc;
    assign o_out.frame_done     = r_fdone;

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= BITS_PER_BYTE)
        else $error("bit counter above byte length");

    a_idle_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left == '0 |-> r_cycle == '0)
        else $error("cycle counter running while shifter idle");

    a_acc_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_acc) |-> !r_fdone)
        else $error("frame done left set by an accepted write");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> $stable(r_bits_left) && $stable(r_hold_full))
        else $error("state moved while result stalled");

endmodule
